// ----- sv/text_console_char_writer_defines.svh -----
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers; clock and reset come from the including module.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcw assertion failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcw assertion failed");

`endif

// ----- sv/tcw_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console writer package
// Field widths, screen defaults, decoded command type and shared codes.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_COLS     = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STEP = 4;

   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
   localparam logic [COL_W-1:0]  RESET_PROMPT = '0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_SETCUR = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_ATTR   = 1'b0,
      CSR_PROMPT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_PRINT   = 3'd0,
      OP_NEWLINE = 3'd1,
      OP_CR      = 3'd2,
      OP_TAB     = 3'd3,
      OP_BS      = 3'd4,
      OP_READ    = 3'd5,
      OP_CLEAR   = 3'd6,
      OP_SETCUR  = 3'd7
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [CHAR_W-1:0]  char_code;
      logic [COL_W-1:0]   target_col;
      logic [ROW_W-1:0]   target_row;
   } cmd_type;

endpackage

// ----- sv/text_console_char_writer.sv -----
// ---------------------------------------------------------------------------
// Text console character writer
// Character-cell screen with cursor: put char, read cell, clear, set cursor.
// ---------------------------------------------------------------------------
//  channel  dir  word layout (low bit up)
//  req_     in   tuser: action; tdata: char_code, target_col, target_row
//  rsp_     out  tdata: cursor_col, cursor_row, cell_value
//  csr_     in   index: 0 text_attribute, 1 prompt_length; data: value
//
//  Put char (no scroll), carriage return, tab, backspace and set cursor finish
//  in S_IDLE; an in-range read cell also passes S_READ (registered RAM read).
//  Clear screen runs the decode cycle, then one RAM write a cycle in S_CLEAR.
//  Newline on the bottom row reads each cell in S_SCR_RD, writes it one row
//  up in S_SCR_WR, then blanks the bottom row in S_SCR_BLANK.
//  After reset a clearing pass fills the screen; queued words wait until it
//  ends. A two-word queue keeps req_ open while a result waits on rsp_.
// ---------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int SCREEN_COLS = tcw_pkg::DEF_COLS,
   parameter int SCREEN_ROWS = tcw_pkg::DEF_ROWS,
   parameter int TAB_STEP    = tcw_pkg::DEF_TAB_STEP
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code, target_col, target_row
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_col, cursor_row, cell_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic [tcw_pkg::COL_W-1:0]  prompt_ff;
   logic                       cmd_valid;
   logic                       cmd_pop;
   tcw_pkg::cmd_type           cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff   <= tcw_pkg::RESET_ATTR;
         prompt_ff <= tcw_pkg::RESET_PROMPT;
      end else if (csr_valid) begin
         case (tcw_pkg::csr_index_type'(csr_index))
            tcw_pkg::CSR_ATTR:   attr_ff   <= csr_data;
            tcw_pkg::CSR_PROMPT: prompt_ff <= csr_data[tcw_pkg::COL_W-1:0];
            default: ;
         endcase
      end
   end

   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   tcw_back #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .TAB_STEP    (TAB_STEP)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd),
      .text_attribute (attr_ff),
      .prompt_length  (prompt_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

// ----- sv/tcw_ram.sv -----
// ---------------------------------------------------------------------------
// Text console writer RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/tcw_front.sv -----
// ---------------------------------------------------------------------------
// Text console writer front end
// Accepts request words, decodes them into commands and queues them.
// ---------------------------------------------------------------------------
module tcw_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   output logic                    cmd_valid,
   input  logic                    cmd_pop,
   output tcw_pkg::cmd_type        cmd
);

   localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

   tcw_pkg::cmd_type  slot_ff [tcw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   tcw_pkg::cmd_type  decoded;
   logic              push;
   logic [tcw_pkg::CHAR_W-1:0] ch;

   assign ch = req_tdata[7:0];

   always_comb begin
      decoded.char_code  = ch;
      decoded.target_col = req_tdata[14:8];
      decoded.target_row = req_tdata[19:15];
      case (tcw_pkg::action_type'(req_tuser))
         tcw_pkg::ACT_PUT: begin
            if (ch == tcw_pkg::CH_LF) begin
               decoded.op = tcw_pkg::OP_NEWLINE;
            end else if (ch == tcw_pkg::CH_CR) begin
               decoded.op = tcw_pkg::OP_CR;
            end else if (ch == tcw_pkg::CH_TAB) begin
               decoded.op = tcw_pkg::OP_TAB;
            end else if (ch == tcw_pkg::CH_BS) begin
               decoded.op = tcw_pkg::OP_BS;
            end else begin
               decoded.op = tcw_pkg::OP_PRINT;
            end
         end
         tcw_pkg::ACT_READ:  decoded.op = tcw_pkg::OP_READ;
         tcw_pkg::ACT_CLEAR: decoded.op = tcw_pkg::OP_CLEAR;
         default:            decoded.op = tcw_pkg::OP_SETCUR;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(tcw_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- sv/tcw_back.sv -----
// ---------------------------------------------------------------------------
// Text console writer back end
// Runs queued commands against the screen RAM and the cursor.
// ---------------------------------------------------------------------------
module tcw_back #(
   parameter int SCREEN_COLS = tcw_pkg::DEF_COLS,
   parameter int SCREEN_ROWS = tcw_pkg::DEF_ROWS,
   parameter int TAB_STEP    = tcw_pkg::DEF_TAB_STEP
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_pop,
   input  tcw_pkg::cmd_type           cmd,
   input  logic [tcw_pkg::ATTR_W-1:0] text_attribute,
   input  logic [tcw_pkg::COL_W-1:0]  prompt_length,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata
);

`include "text_console_char_writer_defines.svh"

   localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;

   localparam logic [COL_W:0]    COLS_X    = (COL_W+1)'(SCREEN_COLS);
   localparam logic [COL_W:0]    TAB_X     = (COL_W+1)'(TAB_STEP);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [ROW_W:0]    ROWS_X    = (ROW_W+1)'(SCREEN_ROWS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(CELLS - SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);

   typedef enum logic [6:0] {
      S_INIT      = 7'b0000001,
      S_IDLE      = 7'b0000010,
      S_READ      = 7'b0000100,
      S_SCR_RD    = 7'b0001000,
      S_SCR_WR    = 7'b0010000,
      S_SCR_BLANK = 7'b0100000,
      S_CLEAR     = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         cnt_ff, cnt_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]          rsp_col_ff;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic [tcw_pkg::CELL_W-1:0] rsp_cell_ff, cell_in;
   logic                      finish;

   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata, blank_cell;

   logic [ADDR_W-1:0]         pos, tpos;
   logic [COL_W:0]            col_p1, col_tab;
   logic [ROW_W-1:0]          row_next;
   logic                      t_in_range;

   assign blank_cell = {text_attribute, tcw_pkg::CH_BLANK};
   assign pos        = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);
   assign tpos       = ADDR_W'(cmd.target_row) * COLS_A + ADDR_W'(cmd.target_col);
   assign col_p1     = {1'b0, col_ff} + (COL_W+1)'(1);
   assign col_tab    = {1'b0, col_ff} + TAB_X;
   assign row_next   = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
   assign t_in_range = ({1'b0, cmd.target_col} < COLS_X) && ({1'b0, cmd.target_row} < ROWS_X);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = blank_cell;
      ram_raddr = cnt_ff + COLS_A;
      finish    = 1'b0;
      cell_in   = '0;
      cmd_pop   = 1'b0;
      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = tcw_pkg::RESET_CELL;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  tcw_pkg::OP_PRINT: begin
                     ram_we    = 1'b1;
                     ram_waddr = pos;
                     ram_wdata = {text_attribute, cmd.char_code};
                     if (col_p1 >= COLS_X) begin
                        col_in = '0;
                        row_in = row_next;
                     end else begin
                        col_in = col_p1[COL_W-1:0];
                     end
                     finish = 1'b1;
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     col_in = '0;
                     if (row_ff != LAST_ROW) begin
                        row_in = row_ff + 1'b1;
                        finish = 1'b1;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_SCR_RD;
                     end
                  end
                  tcw_pkg::OP_CR: begin
                     col_in = '0;
                     finish = 1'b1;
                  end
                  tcw_pkg::OP_TAB: begin
                     if (col_tab >= COLS_X) begin
                        col_in = '0;
                        row_in = row_next;
                     end else begin
                        col_in = col_tab[COL_W-1:0];
                     end
                     finish = 1'b1;
                  end
                  tcw_pkg::OP_BS: begin
                     // refuse at the left edge or inside the prompt
                     if (col_ff != '0 && col_ff > prompt_length) begin
                        ram_we    = 1'b1;
                        ram_waddr = pos - 1'b1;
                        col_in    = col_ff - 1'b1;
                     end
                     finish = 1'b1;
                  end
                  tcw_pkg::OP_READ: begin
                     ram_raddr = tpos;
                     if (t_in_range) begin
                        state_in = S_READ;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     col_in = ({1'b0, cmd.target_col} < COLS_X) ? cmd.target_col : LAST_COL;
                     row_in = ({1'b0, cmd.target_row} < ROWS_X) ? cmd.target_row : LAST_ROW;
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cell_in  = ram_rdata;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         S_SCR_RD: begin
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            // move the cell one row up
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            cnt_in    = cnt_ff + 1'b1;
            state_in  = (cnt_ff == LAST_MOVE) ? S_SCR_BLANK : S_SCR_RD;
         end
         S_SCR_BLANK, S_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_col_ff  <= col_in;
         rsp_row_ff  <= row_in;
         rsp_cell_ff <= cell_in;
      end
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_cell_ff, rsp_row_ff, rsp_col_ff};

   `TCW_ASSERT_NOW(a_pop_when_free, cmd_pop, (state_ff == S_IDLE) && !rsp_valid_ff)
   `TCW_ASSERT_NOW(a_write_in_range, ram_we, ram_waddr <= LAST_ADDR)
   `TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1, (col_ff <= LAST_COL) && (row_ff <= LAST_ROW))
   `TCW_ASSERT_NEXT(a_scroll_ends_bottom, (state_ff == S_SCR_BLANK) && finish,
                    (row_ff == LAST_ROW) && (col_ff == '0))

endmodule

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// Text console writer testbench
// Drives put char, read cell, clear and set cursor words with random gaps on
// both channels, predicts cursor and cell values from a model screen and
// checks every response word in order. Registers change only when idle.
// ---------------------------------------------------------------------------
module testbench;

   localparam int COLS   = tcw_pkg::DEF_COLS;
   localparam int ROWS   = tcw_pkg::DEF_ROWS;
   localparam int CELLS  = COLS * ROWS;
   localparam int LIMIT  = 40000000;
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int CELL_W = tcw_pkg::CELL_W;
   localparam int ATTR_W = tcw_pkg::ATTR_W;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int errors = 0;
   int cycles = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   class console_scoreboard;
      logic [CELL_W-1:0] screen[CELLS];
      int cur_col, cur_row;
      logic [ATTR_W-1:0] attr;
      int prompt;
      rsp_word_type pending[$];

      function void init();
         foreach (screen[i]) screen[i] = tcw_pkg::RESET_CELL;
         cur_col = 0; cur_row = 0; attr = tcw_pkg::RESET_ATTR; prompt = 0;
      endfunction

      function void write_reg(tcw_pkg::csr_index_type idx, logic [7:0] val);
         if (idx == tcw_pkg::CSR_ATTR) attr = val;
         else prompt = int'(val[COL_W-1:0]);
      endfunction

      function void next_line_wrap();
         cur_col = 0;
         cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
      endfunction

      function void note_word(tcw_pkg::action_type act, logic [7:0] ch, int tcol, int trow);
         rsp_word_type w;
         int pos;
         w.cell_value = '0;
         pos = cur_row * COLS + cur_col;
         case (act)
            tcw_pkg::ACT_PUT: begin
               case (ch)
                  tcw_pkg::CH_LF: begin
                     cur_col = 0;
                     if (cur_row + 1 < ROWS) cur_row++;
                     else begin
                        for (int i = 0; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                           screen[i] = {attr, tcw_pkg::CH_BLANK};
                     end
                  end
                  tcw_pkg::CH_CR: cur_col = 0;
                  tcw_pkg::CH_TAB: begin
                     cur_col += tcw_pkg::DEF_TAB_STEP;
                     if (cur_col >= COLS) next_line_wrap();
                  end
                  tcw_pkg::CH_BS: begin
                     if (cur_col != 0 && cur_col > prompt) begin
                        screen[pos - 1] = {attr, tcw_pkg::CH_BLANK};
                        cur_col--;
                     end
                  end
                  default: begin
                     screen[pos] = {attr, ch};
                     cur_col++;
                     if (cur_col >= COLS) next_line_wrap();
                  end
               endcase
            end
            tcw_pkg::ACT_READ:
               if (tcol < COLS && trow < ROWS) w.cell_value = screen[trow * COLS + tcol];
            tcw_pkg::ACT_CLEAR: foreach (screen[i]) screen[i] = {attr, tcw_pkg::CH_BLANK};
            default: begin
               cur_col = (tcol < COLS) ? tcol : COLS - 1;
               cur_row = (trow < ROWS) ? trow : ROWS - 1;
            end
         endcase
         w.col = COL_W'(cur_col);
         w.row = ROW_W'(cur_row);
         pending.push_back(w);
      endfunction

      task check_word(logic [31:0] data);
         rsp_word_type got, want;
         got = data[$bits(rsp_word_type)-1:0];
         if (pending.size() == 0) begin
            report("unexpected word", int'(data), 0);
            return;
         end
         want = pending.pop_front();
         if (got.col != want.col) report("cursor_col", int'(got.col), int'(want.col));
         if (got.row != want.row) report("cursor_row", int'(got.row), int'(want.row));
         if (got.cell_value != want.cell_value)
            report("cell_value", int'(got.cell_value), int'(want.cell_value));
      endtask
   endclass

   console_scoreboard screen_sb = new();

   text_console_char_writer u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: in odd phases random stalls, now and then a long one; check every accepted word
   int stall_mode = 0;
   int hold = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) screen_sb.check_word(rsp_tdata);
      if (stall_mode == 0) rsp_tready <= 1'b1;
      else if (hold > 0) begin
         rsp_tready <= 1'b0;
         hold <= hold - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_tready <= 1'b0;
         hold <= $urandom_range(8, 40);
      end else rsp_tready <= ($urandom_range(0, 99) < 60);
   end

   task automatic send_word(tcw_pkg::action_type act, logic [7:0] ch, int tcol, int trow);
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] r;
      int g;
      c = COL_W'(tcol);
      r = ROW_W'(trow);
      g = gap_length();
      // drop valid only for a gap; a following word keeps it high
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, r, c, ch};
      do @(posedge clock); while (!req_tready);
      screen_sb.note_word(act, ch, int'(c), int'(r));
   endtask

   task automatic write_csr(tcw_pkg::csr_index_type idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      screen_sb.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (screen_sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_word();
      int r;
      logic [7:0] ch;
      r = $urandom_range(0, 99);
      if (r < 62) begin
         // random bytes and control bytes in about equal share
         case ($urandom_range(0, 9))
            0: ch = tcw_pkg::CH_LF;
            1: ch = tcw_pkg::CH_CR;
            2: ch = tcw_pkg::CH_TAB;
            3, 4: ch = tcw_pkg::CH_BS;
            default: ch = 8'($urandom_range(0, 255));
         endcase
         send_word(tcw_pkg::ACT_PUT, ch, $urandom_range(0, 127), $urandom_range(0, 31));
      end else if (r < 84)
         send_word(tcw_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 79),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 24));
      else if (r < 85)
         send_word(tcw_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 127),
                   $urandom_range(0, 31));
      else
         send_word(tcw_pkg::ACT_SETCUR, 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 79),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 24));
   endtask

   initial begin
      screen_sb.init();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: edges of every field and each control byte
      send_word(tcw_pkg::ACT_READ, 8'h00, 0, 0);
      send_word(tcw_pkg::ACT_READ, 8'hFF, 127, 31);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 0, 0);
      send_word(tcw_pkg::ACT_PUT, 8'h00, 0, 0);
      send_word(tcw_pkg::ACT_PUT, 8'hFF, 0, 0);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 0, 0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 0, 0);
      send_word(tcw_pkg::ACT_SETCUR, 8'h00, 127, 31);
      send_word(tcw_pkg::ACT_PUT, 8'h41, 0, 0);
      send_word(tcw_pkg::ACT_SETCUR, 8'h00, 78, 24);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::CH_TAB, 0, 0);
      send_word(tcw_pkg::ACT_SETCUR, 8'h00, 5, 24);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 0, 0);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 0, 0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 0, 23);
      send_word(tcw_pkg::ACT_READ, 8'h00, 79, 24);
      send_word(tcw_pkg::ACT_READ, 8'h00, 80, 0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 0, 25);
      send_word(tcw_pkg::ACT_CLEAR, 8'h00, 0, 0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 40, 12);
      drain();

      // phases over register settings, extremes first
      for (int phase = 0; phase < 8; phase++) begin
         stall_mode = phase % 2;
         case (phase)
            0: begin
               write_csr(tcw_pkg::CSR_ATTR, 8'h00);
               write_csr(tcw_pkg::CSR_PROMPT, 8'd0);
            end
            1: begin
               write_csr(tcw_pkg::CSR_ATTR, 8'hFF);
               write_csr(tcw_pkg::CSR_PROMPT, 8'd79);
            end
            2: begin
               write_csr(tcw_pkg::CSR_ATTR, 8'hA5);
               write_csr(tcw_pkg::CSR_PROMPT, 8'd2);
            end
            3: begin write_csr(tcw_pkg::CSR_PROMPT, 8'd127); end
            default: begin
               write_csr(tcw_pkg::CSR_ATTR, 8'($urandom_range(0, 255)));
               write_csr(tcw_pkg::CSR_PROMPT, 8'($urandom_range(0, 20)));
            end
         endcase
         repeat (200) random_word();
         drain();
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && screen_sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_char_writer.sv
dv/testbench.sv
